// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clock, disabled during reset.
`define CHK_ASSERT(label, clk_s, rst_n, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);
`endif

// ===== src/shah_pkg.sv =====
// Package for the SHA-256/224 hasher: payload types, round constants, IVs.
// No dependencies.
`default_nettype none
package shah_pkg;
	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// queue entry between front and back
	localparam logic [1:0] OP_BLOCK = 2'd0; // full data block
	localparam logic [1:0] OP_FINAL = 2'd1; // last block, then emit digest
	localparam logic [1:0] OP_MID   = 2'd2; // padded block, more follows

	typedef struct packed {
		logic [1:0]   op;
		logic [511:0] block;
	} job_t;

	localparam logic [0:0] VAR_256 = 1'b0;
	localparam logic [0:0] VAR_224 = 1'b1;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [255:0] init_value(input logic v);
		if (v == VAR_224)
			return {32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
				32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
		return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction
endpackage
`default_nettype wire

// ===== src/shah_front.sv =====
// Front end: gathers bytes into blocks, pads at end of message, issues jobs.
// Depends on shah_pkg.
`default_nettype none
module shah_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              restart,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire shah_pkg::in_item_t in_item,
	output logic                   job_valid,
	input  wire logic              job_stall,
	output shah_pkg::job_t         job
);
	logic [511:0] blk_q;
	logic [5:0]   fill_q;
	logic [60:0]  count_q;
	logic         pend_q;   // second padding block still to issue
	logic         jv_q;
	shah_pkg::job_t job_q;
	logic [511:0] pad_blk;
	logic [63:0]  bits;

	assign bits = {count_q, 3'b000};
	assign job_valid = jv_q;
	assign job = job_q;
	assign in_stall = pend_q || (jv_q && job_stall);

	// block with 0x80 at fill position and zeros after
	always_comb begin
		pad_blk = blk_q;
		for (int i = 0; i < 64; i++) begin
			if (6'(i) == fill_q)
				pad_blk[511 - 8*i -: 8] = 8'h80;
			else if (6'(i) > fill_q)
				pad_blk[511 - 8*i -: 8] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			jv_q    <= 1'b0;
		end else if (restart) begin
			fill_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
			jv_q    <= 1'b0;
		end else begin
			if (jv_q && !job_stall)
				jv_q <= 1'b0;
			if (pend_q && !(jv_q && job_stall)) begin
				jv_q      <= 1'b1;
				job_q.op  <= shah_pkg::OP_FINAL;
				job_q.block <= {448'd0, bits};
				pend_q    <= 1'b0;
				count_q   <= '0;
			end else if (in_valid && !in_stall) begin
				if (!in_item.mode) begin
					blk_q[511 - 8*fill_q -: 8] <= in_item.data_byte;
					fill_q  <= fill_q + 6'd1;
					count_q <= count_q + 61'd1;
					if (fill_q == 6'd63) begin
						jv_q  <= 1'b1;
						job_q.op <= shah_pkg::OP_BLOCK;
						job_q.block <= {blk_q[511:8], in_item.data_byte};
					end
				end else begin
					jv_q   <= 1'b1;
					fill_q <= '0;
					if (fill_q >= 6'd56) begin
						job_q.op <= shah_pkg::OP_MID;
						job_q.block <= pad_blk;
						pend_q <= 1'b1;
					end else begin
						job_q.op <= shah_pkg::OP_FINAL;
						job_q.block <= {pad_blk[511:64], bits};
						count_q <= '0;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/shah_queue.sv =====
// Two-entry queue of block jobs between the front and the compression core.
// Depends on shah_pkg.
`default_nettype none
module shah_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           restart,
	input  wire logic           wr_valid,
	output logic                wr_stall,
	input  wire shah_pkg::job_t wr_job,
	output logic                rd_valid,
	input  wire logic           rd_stall,
	output shah_pkg::job_t      rd_job
);
	shah_pkg::job_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop  = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else if (restart) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/shah_core.sv =====
// Compression core: one round per cycle, feed-forward, then digest word emission after a final block.
// Depends on shah_pkg.
`default_nettype none
module shah_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           restart,
	input  wire logic           variant,
	input  wire logic           job_valid,
	output logic                job_stall,
	input  wire shah_pkg::job_t job,
	output logic                out_valid,
	input  wire logic           out_stall,
	output shah_pkg::out_item_t out_item
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]   state_q;
	logic [255:0] chain_q;
	logic [255:0] work_q;
	logic [511:0] w_q;      // sliding window of 16 schedule words
	logic [5:0]   rnd_q;
	logic         fin_q;
	logic [2:0]   widx_q;
	logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn, w0;
	logic [2:0]   last_idx;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign {a, b, c, d, e, f, g, h} = work_q;
	assign w0 = w_q[511:480];
	assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
		+ shah_pkg::round_k(rnd_q) + w0;
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
	assign s0 = rotr(w_q[479:448], 7) ^ rotr(w_q[479:448], 18) ^ (w_q[479:448] >> 3);
	assign s1 = rotr(w_q[63:32], 17) ^ rotr(w_q[63:32], 19) ^ (w_q[63:32] >> 10);
	assign wn = w0 + s0 + w_q[223:192] + s1;
	assign last_idx = (variant == shah_pkg::VAR_224) ? 3'd6 : 3'd7;

	assign job_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_item.digest_word = chain_q[255 - 32*widx_q -: 32];
	assign out_item.word_index  = widx_q;
	assign out_item.last_word   = (widx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chain_q <= shah_pkg::init_value(shah_pkg::VAR_256);
			rnd_q   <= '0;
			widx_q  <= '0;
			fin_q   <= 1'b0;
		end else if (restart) begin
			state_q <= ST_IDLE;
			chain_q <= shah_pkg::init_value(variant);
			rnd_q   <= '0;
			widx_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						work_q  <= chain_q;
						w_q     <= job.block;
						fin_q   <= (job.op == shah_pkg::OP_FINAL);
						rnd_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					work_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
					w_q    <= {w_q[479:0], wn};
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[255 - 32*i -: 32] <= chain_q[255 - 32*i -: 32]
							+ work_q[255 - 32*i -: 32];
					widx_q  <= '0;
					state_q <= fin_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == last_idx) begin
							chain_q <= shah_pkg::init_value(variant);
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/sha256_sha224_hash.sv =====
// SHA-256 / SHA-224 hasher, top level: APB register, front, queue, core.
// Depends on shah_pkg, shah_front, shah_queue, shah_core.
//
// Usage: send message bytes on the in channel (mode 0), one item per byte,
// then one end-of-message item (mode 1). The digest comes out on the out
// channel as 8 big-endian words (7 for SHA-224), last_word on the final one.
// Each full 64-byte block is loaded, put through 64 rounds (one round per cycle)
// and fed forward in the core; the front keeps taking bytes into the next
// block while the core runs. It holds off when the two-entry job queue and
// its own output register are full, and while a second padding block waits
// to be issued. With the core idle, the first digest word is presented once
// the final block has been loaded, run and fed forward (after the second
// padding block too, when one is needed), then one word per cycle unless stalled.
// Sustained rate is about one byte per cycle, bounded by the 64-round loop.
// Reset loads the SHA-256 initial value and clears counters. A write to
// digest_variant (address 0) abandons any message and reloads the chosen
// initial value. A stalled output word simply holds; nothing is lost.
`default_nettype none
module sha256_sha224_hash (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [0:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire shah_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output shah_pkg::out_item_t      out_item
);
	logic variant_q;
	logic restart;
	logic fj_valid, fj_stall, qj_valid, qj_stall;
	shah_pkg::job_t fj, qj;

	assign pready = 1'b1;
	// only register 0 exists; the single paddr bit carries the low address bit
	assign restart = psel && penable && pwrite && (paddr == 1'b0);
	assign prdata  = {31'd0, variant_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			variant_q <= shah_pkg::VAR_256;
		else if (restart)
			variant_q <= pwdata[0];
	end

	shah_front u_front (
		.clk, .arst_n, .restart,
		.in_valid, .in_stall, .in_item,
		.job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
	);

	shah_queue u_queue (
		.clk, .arst_n, .restart,
		.wr_valid(fj_valid), .wr_stall(fj_stall), .wr_job(fj),
		.rd_valid(qj_valid), .rd_stall(qj_stall), .rd_job(qj)
	);

	// variant_q only changes at the write edge, so the core takes the written value directly
	shah_core u_core (
		.clk, .arst_n, .restart(restart), .variant(restart ? pwdata[0] : variant_q),
		.job_valid(qj_valid), .job_stall(qj_stall), .job(qj),
		.out_valid, .out_stall, .out_item
	);
endmodule
`default_nettype wire

// ===== src/shah_checker.sv =====
// Port-level checker for the hasher, bound to the top level.
// Depends on shah_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none
module shah_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire shah_pkg::out_item_t out_item,
	input wire logic                pready
);
	`CHK_ASSERT(a_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled word changed")
	`CHK_ASSERT(a_seq, clk, arst_n, out_valid && !out_stall && !out_item.last_word |=> out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1, "word order broken")
	`CHK_ASSERT(a_last, clk, arst_n, out_valid && out_item.last_word |-> out_item.word_index == 3'd6 || out_item.word_index == 3'd7, "bad last word")
	`CHK_ASSERT(a_rdy, clk, arst_n, pready, "pready low")
endmodule
bind sha256_sha224_hash shah_checker u_chk (.clk, .arst_n, .out_valid, .out_stall, .out_item, .pready);
`default_nettype wire
